// File: src/tiered_block_hash_table_unit_assert.svh
// Assertion helpers for the hash table unit; clk and rst_n come from the using scope.
`ifndef TIERED_BLOCK_HASH_TABLE_UNIT_ASSERT_SVH
`define TIERED_BLOCK_HASH_TABLE_UNIT_ASSERT_SVH

`define TBHU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbhu check failed");

`define TBHU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbhu check failed");

`endif

// File: src/tbh_pkg.sv
`timescale 1ns / 1ps
package tbh_pkg;

    localparam int ID_W       = 64;
    localparam int SIZE_W     = 32;
    localparam int CAP_W      = 48;
    localparam int TIER_W     = 2;
    localparam int NUM_TIER_REGS = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int HASH_SHIFT = 33;

    localparam logic [63:0] HASH_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] HASH_C2 = 64'hc4ceb9fe1a85ec53;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_MOVE  = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_DUPLICATE  = 3'd1;
    localparam logic [2:0] ERR_TIER_FULL  = 3'd2;
    localparam logic [2:0] ERR_TABLE_FULL = 3'd3;
    localparam logic [2:0] ERR_NOT_FOUND  = 3'd4;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ID_W-1:0]   blk_id;
        logic [SIZE_W-1:0] block_size;
        logic [TIER_W-1:0] tier;
    } in_item_t;

    typedef struct packed {
        logic       success;
        logic       resident;
        logic [2:0] error_code;
    } out_item_t;

endpackage

// File: src/tbh_queue.sv
`timescale 1ns / 1ps
module tbh_queue #(
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_stall,
    input  logic [DW-1:0] push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output logic [DW-1:0] pop_data
);
    logic [DW-1:0] entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign push_stall = (cnt_reg == 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && !push_stall;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: src/tbh_front.sv
`timescale 1ns / 1ps
module tbh_front #(
    parameter int AW = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              hold,
    input  logic              in_valid,
    output logic              in_stall,
    input  tbh_pkg::in_item_t in_data,
    output logic              q_valid,
    input  logic              q_stall,
    output tbh_pkg::in_item_t q_req,
    output logic [AW-1:0]     q_home
);
    import tbh_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_HASH = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;
    localparam logic [2:0] LAST_STEP = 3'd5;

    logic [1:0]    state_reg, state_next;
    logic [2:0]    step_reg, step_next;
    in_item_t      req_reg, req_next;
    logic [63:0]   x_reg, x_next;
    logic [63:0]   acc_reg, acc_next;
    logic [AW-1:0] home_reg, home_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod, acc_sum, mixed, cst;
    logic        first_part, last_part;

    assign in_stall = (state_reg != F_IDLE) || hold;
    assign q_valid  = (state_reg == F_PUSH);
    assign q_req    = req_reg;
    assign q_home   = home_reg;

    // 64x64 low product from three 32x32 partial products, one per cycle
    always_comb
    begin
        cst        = (step_reg < 3'd3) ? HASH_C1 : HASH_C2;
        mul_a      = x_reg[31:0];
        mul_b      = cst[31:0];
        first_part = 1'b0;
        last_part  = 1'b0;
        unique case (step_reg)
            3'd0, 3'd3:
            begin
                first_part = 1'b1;
            end
            3'd1, 3'd4:
            begin
                mul_b = cst[63:32];
            end
            3'd2, 3'd5:
            begin
                mul_a     = x_reg[63:32];
                last_part = 1'b1;
            end
            default:
            begin
                mul_a = x_reg[31:0];
            end
        endcase
        prod    = 64'(mul_a) * 64'(mul_b);
        acc_sum = first_part ? prod : acc_reg + {prod[31:0], 32'd0};
        mixed   = acc_sum ^ (acc_sum >> HASH_SHIFT);
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        req_next   = req_reg;
        x_next     = x_reg;
        acc_next   = acc_reg;
        home_next  = home_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    req_next   = in_data;
                    x_next     = in_data.blk_id ^ (in_data.blk_id >> HASH_SHIFT);
                    step_next  = 3'd0;
                    state_next = F_HASH;
                end
            end
            F_HASH:
            begin
                acc_next  = acc_sum;
                step_next = step_reg + 3'd1;
                if (last_part)
                begin
                    x_next = mixed;
                end
                if (step_reg == LAST_STEP)
                begin
                    home_next  = mixed[AW-1:0];
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_stall)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        x_reg    <= x_next;
        acc_reg  <= acc_next;
        home_reg <= home_next;
    end

endmodule

// File: src/tbh_back.sv
`timescale 1ns / 1ps
module tbh_back #(
    parameter int SLOTS = 4096,
    parameter int TIERS = 4,
    parameter int AW    = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tbh_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [tbh_pkg::CAP_W-1:0]     cfg_wdata,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  tbh_pkg::in_item_t             q_req,
    input  logic [AW-1:0]                 q_home,
    output logic                          out_valid,
    input  logic                          out_stall,
    output tbh_pkg::out_item_t            out_data,
    output logic                          clearing
);
    import tbh_pkg::*;

    typedef struct packed {
        logic              valid;
        logic [AW-1:0]     home;
        logic [ID_W-1:0]   key;
        logic [TIER_W-1:0] tier;
        logic [SIZE_W-1:0] bytes;
    } slot_t;

    localparam logic [2:0] B_CLEAR = 3'd0;
    localparam logic [2:0] B_IDLE  = 3'd1;
    localparam logic [2:0] B_LOOK  = 3'd2;
    localparam logic [2:0] B_EXEC  = 3'd3;
    localparam logic [2:0] B_FREE  = 3'd4;
    localparam logic [2:0] B_RESP  = 3'd5;
    localparam logic [AW-1:0] HALF_LOAD = AW'(SLOTS / 2);
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

    slot_t mem [SLOTS];
    slot_t rd_q;

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [AW-1:0]     hole_reg, hole_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [AW-1:0]     count_reg, count_next;
    in_item_t          req_reg, req_next;
    logic [AW-1:0]     home_reg, home_next;
    logic              found_reg, found_next;
    logic [TIER_W-1:0] hit_tier_reg, hit_tier_next;
    logic [SIZE_W-1:0] hit_bytes_reg, hit_bytes_next;
    out_item_t         res_reg, res_next;
    logic [CAP_W-1:0]  cap_reg [NUM_TIER_REGS];
    logic [CAP_W-1:0]  usage_reg [NUM_TIER_REGS];
    logic [CAP_W-1:0]  usage_next [NUM_TIER_REGS];
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    slot_t         mem_wdata, slot_inv;
    logic [SIZE_W-1:0] fit_bytes;
    logic [CAP_W:0]    fit_sum;
    logic              fits;
    logic [AW-1:0]     dist_hole, dist_cur;

    assign clearing  = (state_reg == B_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        slot_inv       = rd_q;
        slot_inv.valid = 1'b0;
        fit_bytes = (req_reg.cmd == CMD_ALLOC) ? req_reg.block_size : hit_bytes_reg;
        fit_sum   = {1'b0, usage_reg[req_reg.tier]} + (CAP_W + 1)'(fit_bytes);
        fits      = ({1'b0, req_reg.tier} < 3'(TIERS))
                    && (fit_sum <= {1'b0, cap_reg[req_reg.tier]});
        // circular distance from the entry's home: move it into the hole if nearer home
        dist_hole = hole_reg - rd_q.home;
        dist_cur  = addr_reg - rd_q.home;
    end

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        hole_next      = hole_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        req_next       = req_reg;
        home_next      = home_reg;
        found_next     = found_reg;
        hit_tier_next  = hit_tier_reg;
        hit_bytes_next = hit_bytes_reg;
        res_next       = res_reg;
        usage_next     = usage_reg;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = slot_inv;
        mem_re         = 1'b0;
        mem_raddr      = addr_reg + AW'(1);
        q_pop          = 1'b0;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            B_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    req_next   = q_req;
                    home_next  = q_home;
                    addr_next  = q_home;
                    mem_re     = 1'b1;
                    mem_raddr  = q_home;
                    state_next = B_LOOK;
                end
            end
            B_LOOK:
            begin
                if (!rd_q.valid)
                begin
                    found_next = 1'b0;
                    state_next = B_EXEC;
                end
                else if (rd_q.key == req_reg.blk_id)
                begin
                    found_next     = 1'b1;
                    hit_tier_next  = rd_q.tier;
                    hit_bytes_next = rd_q.bytes;
                    state_next     = B_EXEC;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                    mem_re    = 1'b1;
                end
            end
            B_EXEC:
            begin
                res_next   = '{success: 1'b0, resident: 1'b0, error_code: ERR_NONE};
                state_next = B_RESP;
                unique case (req_reg.cmd)
                    CMD_ALLOC:
                    begin
                        if (found_reg)
                        begin
                            res_next.error_code = ERR_DUPLICATE;
                        end
                        else if (!fits)
                        begin
                            res_next.error_code = ERR_TIER_FULL;
                        end
                        else if (count_reg >= HALF_LOAD)
                        begin
                            res_next.error_code = ERR_TABLE_FULL;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = '{valid: 1'b1, home: home_reg, key: req_reg.blk_id,
                                          tier: req_reg.tier, bytes: req_reg.block_size};
                            count_next = count_reg + AW'(1);
                            usage_next[req_reg.tier] = fit_sum[CAP_W-1:0];
                            res_next.success = 1'b1;
                        end
                    end
                    CMD_FREE:
                    begin
                        if (!found_reg)
                        begin
                            res_next.error_code = ERR_NOT_FOUND;
                        end
                        else
                        begin
                            usage_next[hit_tier_reg] = usage_reg[hit_tier_reg]
                                                       - CAP_W'(hit_bytes_reg);
                            count_next = count_reg - AW'(1);
                            hole_next  = addr_reg;
                            addr_next  = addr_reg + AW'(1);
                            mem_re     = 1'b1;
                            res_next.success = 1'b1;
                            state_next = B_FREE;
                        end
                    end
                    CMD_MOVE:
                    begin
                        if (!found_reg)
                        begin
                            res_next.error_code = ERR_NOT_FOUND;
                        end
                        else if (hit_tier_reg == req_reg.tier)
                        begin
                            res_next.success = 1'b1;
                        end
                        else if (!fits)
                        begin
                            res_next.error_code = ERR_TIER_FULL;
                        end
                        else
                        begin
                            for (int t = 0; t < NUM_TIER_REGS; t++)
                            begin
                                if (TIER_W'(t) == hit_tier_reg)
                                begin
                                    usage_next[t] = usage_reg[t] - CAP_W'(hit_bytes_reg);
                                end
                                else if (TIER_W'(t) == req_reg.tier)
                                begin
                                    usage_next[t] = fit_sum[CAP_W-1:0];
                                end
                            end
                            mem_we    = 1'b1;
                            mem_wdata = '{valid: 1'b1, home: home_reg, key: req_reg.blk_id,
                                          tier: req_reg.tier, bytes: hit_bytes_reg};
                            res_next.success = 1'b1;
                        end
                    end
                    CMD_QUERY:
                    begin
                        res_next.success  = 1'b1;
                        res_next.resident = found_reg;
                    end
                    default:
                    begin
                        res_next.error_code = ERR_NONE;
                    end
                endcase
            end
            B_FREE:
            begin
                // the hole is never written invalid until the cluster ends
                if (!rd_q.valid || (addr_reg == hole_reg))
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = hole_reg;
                    mem_wdata  = slot_inv;
                    state_next = B_RESP;
                end
                else
                begin
                    if (dist_hole < dist_cur)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = hole_reg;
                        mem_wdata = rd_q;
                        hole_next = addr_reg;
                    end
                    addr_next = addr_reg + AW'(1);
                    mem_re    = 1'b1;
                end
            end
            B_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int t = 0; t < NUM_TIER_REGS; t++)
            begin
                usage_reg[t] <= '0;
                cap_reg[t]   <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            usage_reg     <= usage_next;
            if (cfg_we)
            begin
                cap_reg[cfg_addr] <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        hole_reg      <= hole_next;
        req_reg       <= req_next;
        home_reg      <= home_next;
        found_reg     <= found_next;
        hit_tier_reg  <= hit_tier_next;
        hit_bytes_reg <= hit_bytes_next;
        res_reg       <= res_next;
        out_data_reg  <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_q <= mem[mem_raddr];
        end
    end

endmodule

// File: src/tiered_block_hash_table_unit.sv
// The front hashes each request with one shared 32x32 multiplier (six products); the back then
//   probes on from the home slot to a hit or an empty slot, and a free also walks its cluster.
// The front takes no new request until the last is hashed and handed on, so its shared multiplier
//   sets the rate, or the back's slot memory does when probe chains or clusters are long.
// Reset: asynchronous, active low; afterward a clearing pass runs over every slot of the
//   slot memory while no request is accepted. SLOTS must be a power of two; not checked.
`timescale 1ns / 1ps
`include "tiered_block_hash_table_unit_assert.svh"
module tiered_block_hash_table_unit #(
    parameter int SLOTS = 4096,
    parameter int TIERS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tbh_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [tbh_pkg::CAP_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  tbh_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output tbh_pkg::out_item_t            out_data
);
    import tbh_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int QW = $bits(in_item_t) + AW;

    logic          clearing;
    logic          fq_valid, fq_stall;
    in_item_t      fq_req;
    logic [AW-1:0] fq_home;
    logic          q_valid, q_pop;
    logic [QW-1:0] q_data;
    in_item_t      q_req;
    logic [AW-1:0] q_home;

    assign q_req  = in_item_t'(q_data[QW-1:AW]);
    assign q_home = q_data[AW-1:0];

    tbh_front #(.AW(AW)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .hold     (clearing),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (fq_valid),
        .q_stall  (fq_stall),
        .q_req    (fq_req),
        .q_home   (fq_home)
    );

    tbh_queue #(.DW(QW)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_stall (fq_stall),
        .push_data  ({fq_req, fq_home}),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_data   (q_data)
    );

    tbh_back #(.SLOTS(SLOTS), .TIERS(TIERS), .AW(AW)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_req     (q_req),
        .q_home    (q_home),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .clearing  (clearing)
    );

    `TBHU_ASSERT_IMP(a_no_accept_in_clear, clearing, in_stall)
    `TBHU_ASSERT_IMP(a_no_result_in_clear, clearing, !out_valid)
    `TBHU_ASSERT_NXT(a_queue_empty_after_clear, clearing, clearing || !q_valid)

endmodule

// File: tb/sv/tiered_block_hash_table_unit_test.sv
`timescale 1ns / 1ps
module tiered_block_hash_table_unit_test;
    import tbh_pkg::*;

    localparam int SLOTS      = 4096;
    localparam int TIERS      = 4;
    localparam int IDLE_LIMIT = 20000;

    localparam logic [CFG_IDX_W-1:0] REG_CAP_TIER0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAP_TIER1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAP_TIER2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAP_TIER3 = 2'd3;

    localparam logic [CAP_W-1:0] CAP_MAX = {CAP_W{1'b1}};

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CAP_W-1:0] cfg_wdata;
    logic             in_valid;
    logic             in_stall;
    in_item_t         in_data;
    logic             out_valid;
    logic             out_stall;
    out_item_t        out_data;

    tiered_block_hash_table_unit #(.SLOTS(SLOTS), .TIERS(TIERS)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    // shadow copy of the table
    bit          tbl_used [SLOTS];
    logic [63:0] tbl_id   [SLOTS];
    logic [1:0]  tbl_tier [SLOTS];
    logic [31:0] tbl_size [SLOTS];
    logic [47:0] usage    [4];
    logic [47:0] cap      [4];
    int          n_entries;
    logic [63:0] live_ids [$];

    out_item_t   expected_results [$];
    int          errors;
    int          burst_left;
    int          idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [11:0] home_of(logic [63:0] id);
        logic [63:0] h;
        h = id;
        h = h ^ (h >> HASH_SHIFT);
        h = h * HASH_C1;
        h = h ^ (h >> HASH_SHIFT);
        h = h * HASH_C2;
        h = h ^ (h >> HASH_SHIFT);
        return h[11:0];
    endfunction

    function automatic int find_slot(logic [63:0] id);
        logic [11:0] s;
        s = home_of(id);
        for (int n = 0; n < SLOTS; n++)
        begin
            if (!tbl_used[s])
                return -1;
            if (tbl_id[s] == id)
                return int'(s);
            s = s + 12'd1;
        end
        return -1;
    endfunction

    function automatic logic [11:0] empty_slot(logic [63:0] id);
        logic [11:0] s;
        s = home_of(id);
        for (int n = 0; n < SLOTS; n++)
        begin
            if (!tbl_used[s])
                return s;
            s = s + 12'd1;
        end
        return s;
    endfunction

    function automatic bit fits(logic [1:0] t, logic [31:0] bytes);
        return ({1'b0, usage[t]} + 49'(bytes)) <= {1'b0, cap[t]};
    endfunction

    function automatic void drop_live(logic [63:0] id);
        int q[$];
        q = live_ids.find_first_index(x) with (x == id);
        if (q.size() > 0)
            live_ids.delete(q[0]);
    endfunction

    function automatic out_item_t table_outcome(in_item_t r);
        out_item_t   o;
        int          f;
        logic [11:0] s;
        logic [11:0] i;
        logic [11:0] d;
        logic [63:0] k;
        logic [1:0]  kt;
        logic [31:0] kb;
        logic [1:0]  old;
        o = '0;
        f = find_slot(r.blk_id);
        case (r.cmd)
            CMD_ALLOC:
            begin
                if (f >= 0)
                    o.error_code = ERR_DUPLICATE;
                else if (!fits(r.tier, r.block_size))
                    o.error_code = ERR_TIER_FULL;
                else if (n_entries >= SLOTS / 2)
                    o.error_code = ERR_TABLE_FULL;
                else
                begin
                    s = empty_slot(r.blk_id);
                    tbl_used[s] = 1'b1;
                    tbl_id[s]   = r.blk_id;
                    tbl_tier[s] = r.tier;
                    tbl_size[s] = r.block_size;
                    n_entries++;
                    usage[r.tier] = usage[r.tier] + 48'(r.block_size);
                    live_ids.push_back(r.blk_id);
                    o.success = 1'b1;
                end
            end
            CMD_FREE:
            begin
                if (f < 0)
                    o.error_code = ERR_NOT_FOUND;
                else
                begin
                    s = 12'(f);
                    usage[tbl_tier[s]] = usage[tbl_tier[s]] - 48'(tbl_size[s]);
                    tbl_used[s] = 1'b0;
                    n_entries--;
                    drop_live(r.blk_id);
                    // re-place the rest of the cluster
                    i = s + 12'd1;
                    for (int n = 0; n < SLOTS && tbl_used[i]; n++)
                    begin
                        k  = tbl_id[i];
                        kt = tbl_tier[i];
                        kb = tbl_size[i];
                        tbl_used[i] = 1'b0;
                        d = empty_slot(k);
                        tbl_used[d] = 1'b1;
                        tbl_id[d]   = k;
                        tbl_tier[d] = kt;
                        tbl_size[d] = kb;
                        i = i + 12'd1;
                    end
                    o.success = 1'b1;
                end
            end
            CMD_MOVE:
            begin
                if (f < 0)
                    o.error_code = ERR_NOT_FOUND;
                else
                begin
                    s = 12'(f);
                    old = tbl_tier[s];
                    if (old == r.tier)
                        o.success = 1'b1;
                    else if (!fits(r.tier, tbl_size[s]))
                        o.error_code = ERR_TIER_FULL;
                    else
                    begin
                        usage[old]    = usage[old] - 48'(tbl_size[s]);
                        usage[r.tier] = usage[r.tier] + 48'(tbl_size[s]);
                        tbl_tier[s]   = r.tier;
                        o.success     = 1'b1;
                    end
                end
            end
            default:
            begin
                o.success  = 1'b1;
                o.resident = (f >= 0);
            end
        endcase
        return o;
    endfunction

    // receiver stall pattern: modes change every so often
    int stall_mode;
    int stall_cnt;
    initial
    begin
        out_stall  = 1'b0;
        stall_mode = 0;
        stall_cnt  = 0;
        forever
        begin
            @(negedge clk);
            stall_cnt++;
            if (stall_cnt % 300 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 2) == 0);
                2: out_stall <= (stall_cnt % 5) < 2;
                default: out_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, actual %p", $time, out_data);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_data.success !== want.success)
                begin
                    $display("%0t: success expected %0b actual %0b",
                             $time, want.success, out_data.success);
                    errors++;
                end
                if (out_data.resident !== want.resident)
                begin
                    $display("%0t: resident expected %0b actual %0b",
                             $time, want.resident, out_data.resident);
                    errors++;
                end
                if (out_data.error_code !== want.error_code)
                begin
                    $display("%0t: error_code expected %0d actual %0d",
                             $time, want.error_code, out_data.error_code);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_req(in_item_t r);
        @(negedge clk);
        if (burst_left <= 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(table_outcome(r));
    endtask

    task automatic issue(logic [1:0] c, logic [63:0] id, logic [31:0] sz, logic [1:0] t);
        in_item_t r;
        r.cmd        = c;
        r.blk_id     = id;
        r.block_size = sz;
        r.tier       = t;
        send_req(r);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        cap[idx]   = val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_caps(logic [47:0] c0, logic [47:0] c1, logic [47:0] c2,
                            logic [47:0] c3);
        drain();
        write_reg(REG_CAP_TIER0, c0);
        write_reg(REG_CAP_TIER1, c1);
        write_reg(REG_CAP_TIER2, c2);
        write_reg(REG_CAP_TIER3, c3);
    endtask

    function automatic logic [63:0] fresh_id();
        return {$urandom, $urandom};
    endfunction

    task automatic test_directed();
        logic [63:0] ones;
        ones = '1;
        set_caps(CAP_MAX, 48'd100, 48'd0, CAP_MAX);
        issue(CMD_QUERY, 64'd0, 32'd0, 2'd0);
        issue(CMD_ALLOC, 64'd0, 32'd0, 2'd0);
        issue(CMD_ALLOC, ones, 32'hFFFF_FFFF, 2'd3);
        issue(CMD_ALLOC, 64'd0, 32'd5, 2'd1);          // duplicate
        issue(CMD_ALLOC, 64'd7, 32'd101, 2'd1);        // over tier capacity
        issue(CMD_ALLOC, 64'd8, 32'd1, 2'd2);          // zero-capacity tier
        issue(CMD_ALLOC, 64'd9, 32'd100, 2'd1);        // exactly fills
        issue(CMD_QUERY, ones, 32'd0, 2'd0);
        issue(CMD_MOVE, ones, 32'd0, 2'd3);            // same tier
        issue(CMD_MOVE, ones, 32'd0, 2'd1);            // tier 1 full
        issue(CMD_MOVE, 64'd0, 32'd0, 2'd1);           // size 0 fits
        issue(CMD_MOVE, 64'd12345, 32'd0, 2'd0);       // unknown
        issue(CMD_FREE, 64'd12345, 32'd0, 2'd0);       // unknown
        issue(CMD_FREE, 64'd9, 32'd0, 2'd0);
        issue(CMD_ALLOC, 64'd10, 32'd100, 2'd1);
        issue(CMD_FREE, ones, 32'd0, 2'd0);
        issue(CMD_QUERY, ones, 32'd0, 2'd0);
        issue(CMD_FREE, 64'd0, 32'd0, 2'd0);
        issue(CMD_FREE, 64'd10, 32'd0, 2'd0);
        issue(CMD_QUERY, 64'd10, 32'd0, 2'd0);
    endtask

    // load part of the table, then empty it so frees walk and re-place clusters
    task automatic test_cluster_free();
        logic [63:0] id;
        set_caps(CAP_MAX, CAP_MAX, CAP_MAX, CAP_MAX);
        repeat (200)
            issue(CMD_ALLOC, fresh_id(), $urandom_range(0, 255), 2'($urandom));
        issue(CMD_ALLOC, live_ids[0], 32'd1, 2'd0);
        issue(CMD_QUERY, live_ids[$], 32'd0, 2'd0);
        drain();
        while (live_ids.size() > 0)
        begin
            id = live_ids[$urandom_range(0, live_ids.size() - 1)];
            issue(CMD_FREE, id, 32'd0, 2'd0);
            if ($urandom_range(0, 7) == 0)
                issue(CMD_QUERY, live_ids.size() > 0 ? live_ids[0] : id, 32'd0, 2'd0);
        end
    endtask

    task automatic random_phase(int count);
        logic [63:0] id;
        logic [31:0] sz;
        int          pick;
        logic [1:0]  c;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (live_ids.size() > 0 && pick < 55)
                id = live_ids[$urandom_range(0, live_ids.size() - 1)];
            else if (pick < 62)
                id = $urandom_range(0, 1) ? 64'd0 : '1;
            else
                id = fresh_id();
            pick = $urandom_range(0, 99);
            c = pick < 40 ? CMD_ALLOC : pick < 60 ? CMD_FREE : pick < 80 ? CMD_MOVE
                : CMD_QUERY;
            sz = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4096);
            issue(c, id, sz, 2'($urandom));
        end
    endtask

    task automatic test_random();
        set_caps(CAP_MAX, CAP_MAX, CAP_MAX, CAP_MAX);
        random_phase(200);
        set_caps({16'd0, $urandom} << 4, 48'd0, CAP_MAX,
                 {16'($urandom_range(0, 65535)), $urandom});
        random_phase(200);
        set_caps(48'd0, 48'd0, 48'd0, 48'd0);
        random_phase(100);
        set_caps(48'h1_0000_0000, 48'h8_0000_0000, 48'h2_0000_0000, 48'hFFFF_FFFF);
        random_phase(350);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        in_data     = '0;
        errors      = 0;
        burst_left  = 0;
        idle_cycles = 0;
        n_entries   = 0;
        for (int i = 0; i < 4; i++)
        begin
            usage[i] = '0;
            cap[i]   = '0;
        end
        for (int i = 0; i < SLOTS; i++)
            tbl_used[i] = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_cluster_free();
        test_random();

        drain();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
